// File: hw/rtl/dps_pkg.sv
// ----------------------------------------------------------------------------
// dps_pkg
// Shared types, constants and helpers for the downlink partition scheduler.
// ----------------------------------------------------------------------------
package dps_pkg;

  localparam int DPS_PARTITIONS = 16;

  localparam int IDX_W   = 4;
  localparam int BITS_W  = 32;
  localparam int RATE_W  = 24;
  localparam int TICKS_W = 16;
  localparam int INC_W   = RATE_W + TICKS_W;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_PACKET_BITS = 1'b0,
    REG_RATE        = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [BITS_W-1:0] packet_bits;
    logic [RATE_W-1:0] rate;
  } cfg_t;

  // registered input beat, with rate * ticks already formed
  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [BITS_W-1:0] stored;
    logic              last;
    logic              access;
    logic [INC_W-1:0]  inc;
  } in_item_t;

  typedef struct packed {
    logic              sel;
    logic [IDX_W-1:0]  sel_idx;
    logic [RATE_W-1:0] rate;
    logic [BITS_W-1:0] progress;
  } result_t;

  // grow sent bits by inc (saturating at all ones), or take the available amount if it is smaller than inc
  function automatic logic [BITS_W-1:0] advance(input logic [BITS_W-1:0] sent,
                                                input logic [BITS_W-1:0] avail,
                                                input logic [INC_W-1:0]  inc);
    logic [INC_W:0] sum;
    sum = {{(INC_W+1-BITS_W){1'b0}}, sent} + {1'b0, inc};
    if ({{(INC_W-BITS_W){1'b0}}, avail} < inc) begin
      return avail;
    end
    if (sum[INC_W:BITS_W] != '0) begin
      return '1;
    end
    return sum[BITS_W-1:0];
  endfunction

endpackage

// File: hw/rtl/dps_in_stage.sv
// ----------------------------------------------------------------------------
// dps_in_stage
// Input register; forms the per-tick increment as the beat is taken.
// ----------------------------------------------------------------------------
module dps_in_stage import dps_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [IDX_W-1:0]   partition_index,
  input  logic [BITS_W-1:0]  stored_bits,
  input  logic               last_partition,
  input  logic               ground_access,
  input  logic [TICKS_W-1:0] elapsed_ticks,
  input  logic [RATE_W-1:0]  rate,
  input  logic               go,
  output logic               item_valid,
  output in_item_t           item
);

  always_comb begin
    in_stall = item_valid && !go;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item.idx    <= partition_index;
      item.stored <= stored_bits;
      item.last   <= last_partition;
      item.access <= ground_access;
      item.inc    <= INC_W'(rate) * INC_W'(elapsed_ticks);
    end
  end

endmodule

// File: hw/rtl/dps_sched_core.sv
// ----------------------------------------------------------------------------
// dps_sched_core
// Running maximum and current-partition tracking; tick-close decision.
// ----------------------------------------------------------------------------
module dps_sched_core import dps_pkg::*; #(
  parameter int PARTITIONS = DPS_PARTITIONS
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     go,
  input  in_item_t item,
  input  cfg_t     cfg,
  output logic     res_load,
  output result_t  res
);

  logic [IDX_W-1:0]  cur_part,  cur_part_next;
  logic              cur_valid, cur_valid_next;
  logic [BITS_W-1:0] sent_in_packet, sent_next;
  logic [IDX_W-1:0]  best_partition;
  logic [BITS_W-1:0] best_amount;
  logic              best_seen;
  logic [BITS_W-1:0] current_amount;
  logic              current_found;

  logic              idx_ok, take, match;
  logic [IDX_W-1:0]  b_part_n;
  logic [BITS_W-1:0] b_amt_n, c_amt_n;
  logic              b_seen_n, c_found_n;
  logic [BITS_W-1:0] sent0, sent1, sel_amt;
  logic              cont, drop, any_thr, pick_best, sel, send;
  logic [IDX_W-1:0]  sel_idx;

  always_comb begin
    idx_ok    = ({{(32-IDX_W){1'b0}}, item.idx} < 32'(PARTITIONS));
    take      = idx_ok && (!best_seen || item.stored > best_amount);
    match     = idx_ok && cur_valid && (item.idx == cur_part);
    b_seen_n  = best_seen || idx_ok;
    b_amt_n   = take ? item.stored : best_amount;
    b_part_n  = take ? item.idx : best_partition;
    c_found_n = current_found || match;
    c_amt_n   = match ? item.stored : current_amount;

    // finished packet starts over
    sent0     = (sent_in_packet >= cfg.packet_bits) ? '0 : sent_in_packet;
    cont      = (sent0 != '0) && c_found_n && (c_amt_n != '0);
    drop      = (sent0 != '0) && !cont;
    any_thr   = !(drop && c_found_n);
    sent1     = drop ? '0 : sent0;
    pick_best = (sent1 == '0) && b_seen_n && (any_thr || b_amt_n != '0);
    sel       = cont || pick_best;
    sel_idx   = cont ? cur_part : b_part_n;
    sel_amt   = cont ? c_amt_n : b_amt_n;
    send      = item.access && sel;

    cur_part_next  = cur_part;
    cur_valid_next = cur_valid;
    sent_next      = '0;
    res.rate       = cfg.rate;
    if (drop || !send) begin
      res.rate = '0;
    end
    if (send) begin
      if (sent1 == '0) begin
        cur_part_next  = sel_idx;
        cur_valid_next = 1'b1;
        if (sel_amt < cfg.packet_bits) begin
          res.rate = '0;
        end else begin
          sent_next = advance('0, sel_amt, item.inc);
        end
      end else begin
        sent_next = advance(sent1, sel_amt, item.inc);
      end
    end

    res.sel      = send;
    res.sel_idx  = send ? sel_idx : '0;
    res.progress = sent_next;
    res_load     = go && item.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_part       <= '0;
      cur_valid      <= 1'b0;
      sent_in_packet <= '0;
      best_partition <= '0;
      best_amount    <= '0;
      best_seen      <= 1'b0;
      current_amount <= '0;
      current_found  <= 1'b0;
    end else if (go) begin
      if (item.last) begin
        cur_part       <= cur_part_next;
        cur_valid      <= cur_valid_next;
        sent_in_packet <= sent_next;
        best_partition <= '0;
        best_amount    <= '0;
        best_seen      <= 1'b0;
        current_amount <= '0;
        current_found  <= 1'b0;
      end else begin
        best_partition <= b_part_n;
        best_amount    <= b_amt_n;
        best_seen      <= b_seen_n;
        current_amount <= c_amt_n;
        current_found  <= c_found_n;
      end
    end
  end

endmodule

// File: hw/rtl/downlink_partition_scheduler.sv
// ----------------------------------------------------------------------------
// downlink_partition_scheduler
// Per-tick downlink scheduler over storage partition fill levels.
//
// Input beats carry one partition each (index, stored bits); the beat with
// last_partition set closes the tick and also carries ground_access and
// elapsed_ticks. Exactly one result beat follows each closing beat: the
// chosen partition, the transmit rate and the packet progress.
// Config writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are always taken
// and must only happen while the block is idle.
// Throughput: one input beat per cycle while in_stall is low. A closing beat's
// result passes the input register, then the result register, before it is
// shown; the rate * ticks product sits ahead of the input register.
// When out_stall holds a pending result, non-closing beats keep flowing and
// a closing beat waits in the input register, raising in_stall.
// Reset clears the config registers, the current partition, the sent count
// and the per-tick accumulators; no result is pending after reset.
// ----------------------------------------------------------------------------
module downlink_partition_scheduler import dps_pkg::*; #(
  parameter int PARTITIONS = DPS_PARTITIONS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [IDX_W-1:0]   partition_index,
  input  logic [BITS_W-1:0]  stored_bits,
  input  logic               last_partition,
  input  logic               ground_access,
  input  logic [TICKS_W-1:0] elapsed_ticks,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               selection_valid,
  output logic [IDX_W-1:0]   selected_partition,
  output logic [RATE_W-1:0]  transmit_rate,
  output logic [BITS_W-1:0]  packet_progress,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  cfg_reg_t           cfg_index,
  input  logic [BITS_W-1:0]  cfg_data
);

  cfg_t     cfg;
  in_item_t item;
  logic     item_valid, go, res_load, out_free;
  result_t  res, res_q;

  always_comb begin
    cfg_ready = 1'b1;
    out_free  = !out_valid || !out_stall;
    // a closing beat needs room in the result register
    go        = item_valid && (!item.last || out_free);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.packet_bits <= '0;
      cfg.rate        <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PACKET_BITS: cfg.packet_bits <= cfg_data;
        REG_RATE:        cfg.rate        <= cfg_data[RATE_W-1:0];
        default:         cfg.rate        <= cfg.rate;
      endcase
    end
  end

  dps_in_stage u_in (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .partition_index (partition_index),
    .stored_bits     (stored_bits),
    .last_partition  (last_partition),
    .ground_access   (ground_access),
    .elapsed_ticks   (elapsed_ticks),
    .rate            (cfg.rate),
    .go              (go),
    .item_valid      (item_valid),
    .item            (item)
  );

  dps_sched_core #(
    .PARTITIONS (PARTITIONS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .go       (go),
    .item     (item),
    .cfg      (cfg),
    .res_load (res_load),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_q <= res;
    end
  end

  assign selection_valid    = res_q.sel;
  assign selected_partition = res_q.sel_idx;
  assign transmit_rate      = res_q.rate;
  assign packet_progress    = res_q.progress;

endmodule

// File: test/downlink_partition_scheduler_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// downlink_partition_scheduler_checker
// Watches the partition, result and register channels of the scheduler. It
// keeps its own copy of the scheduling state and queues the expected
// selection for every closing beat. It then compares each result beat
// against the oldest queued selection.
// ----------------------------------------------------------------------------
module downlink_partition_scheduler_checker import dps_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [IDX_W-1:0]   partition_index,
  input  logic [BITS_W-1:0]  stored_bits,
  input  logic               last_partition,
  input  logic               ground_access,
  input  logic [TICKS_W-1:0] elapsed_ticks,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               selection_valid,
  input  logic [IDX_W-1:0]   selected_partition,
  input  logic [RATE_W-1:0]  transmit_rate,
  input  logic [BITS_W-1:0]  packet_progress,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  cfg_reg_t           cfg_index,
  input  logic [BITS_W-1:0]  cfg_data,
  output int                 fail_count,
  output int                 pending_results,
  output int                 checked_results
);

  result_t expected_selections[$];

  logic [BITS_W-1:0] pkt_bits;
  logic [RATE_W-1:0] rate_cfg;

  logic [IDX_W-1:0]  cur_part;
  logic              cur_valid;
  logic [BITS_W-1:0] sent_bits;
  logic [IDX_W-1:0]  best_part;
  logic [BITS_W-1:0] best_amt;
  logic              best_seen;
  logic [BITS_W-1:0] cur_amt;
  logic              cur_found;

  int fails = 0;
  int checked = 0;

  // sent bits after a tick: capped by what the partition holds, then by 32 bits
  function automatic logic [BITS_W-1:0] grow_sent(input logic [BITS_W-1:0] sent,
                                                  input logic [BITS_W-1:0] avail,
                                                  input logic [INC_W-1:0]  inc);
    logic [63:0] total;
    total = 64'(sent) + 64'(inc);
    if (64'(avail) < 64'(inc)) begin
      return avail;
    end
    if (total > 64'hFFFF_FFFF) begin
      return '1;
    end
    return total[BITS_W-1:0];
  endfunction

  task automatic clear_tick();
    best_part = '0;
    best_amt  = '0;
    best_seen = 1'b0;
    cur_amt   = '0;
    cur_found = 1'b0;
  endtask

  task automatic schedule_partition(input logic [IDX_W-1:0]   idx,
                                    input logic [BITS_W-1:0]  stored,
                                    input logic               closing,
                                    input logic               access,
                                    input logic [TICKS_W-1:0] ticks);
    logic [BITS_W-1:0] sent;
    logic [BITS_W-1:0] pick_amt;
    logic [IDX_W-1:0]  pick_idx;
    logic [RATE_W-1:0] rate_now;
    logic              pick;
    logic              any_amount;
    logic [INC_W-1:0]  inc;
    result_t           sel;
    // a 4-bit index never reaches past the 16 partitions
    if (!best_seen || stored > best_amt) begin
      best_seen = 1'b1;
      best_amt  = stored;
      best_part = idx;
    end
    if (cur_valid && idx == cur_part) begin
      cur_found = 1'b1;
      cur_amt   = stored;
    end
    if (closing) begin
      sent       = sent_bits;
      rate_now   = rate_cfg;
      pick       = 1'b0;
      pick_idx   = '0;
      pick_amt   = '0;
      any_amount = 1'b1;
      if (sent >= pkt_bits) begin
        sent = '0;
      end
      if (sent != '0) begin
        if (cur_found && cur_amt != '0) begin
          pick     = 1'b1;
          pick_idx = cur_part;
          pick_amt = cur_amt;
        end else begin
          // current partition drained: only non-empty ones may follow it
          if (cur_found) begin
            any_amount = 1'b0;
          end
          sent     = '0;
          rate_now = '0;
        end
      end
      if (sent == '0 && best_seen && (any_amount || best_amt != '0)) begin
        pick     = 1'b1;
        pick_idx = best_part;
        pick_amt = best_amt;
      end
      inc = {{(INC_W-RATE_W){1'b0}}, rate_cfg} * {{(INC_W-TICKS_W){1'b0}}, ticks};
      if (access && pick) begin
        if (sent == '0) begin
          cur_part  = pick_idx;
          cur_valid = 1'b1;
          if (pick_amt < pkt_bits) begin
            rate_now = '0;
          end else begin
            sent = grow_sent(sent, pick_amt, inc);
          end
        end else begin
          sent = grow_sent(sent, pick_amt, inc);
        end
      end else begin
        pick     = 1'b0;
        rate_now = '0;
        sent     = '0;
      end
      sent_bits = sent;
      clear_tick();
      sel.sel      = pick;
      sel.sel_idx  = pick ? pick_idx : '0;
      sel.rate     = rate_now;
      sel.progress = sent;
      expected_selections = {expected_selections, sel};
    end
  endtask

  task automatic check_result();
    result_t want;
    if (expected_selections.size() == 0) begin
      fails++;
      if (fails <= 10) begin
        $display("ERROR: result beat with nothing expected: sel=%0d part=%0d rate=%0d prog=%0d",
                 selection_valid, selected_partition, transmit_rate, packet_progress);
      end
    end else begin
      want = expected_selections.pop_front();
      checked++;
      if (selection_valid !== want.sel || selected_partition !== want.sel_idx ||
          transmit_rate !== want.rate || packet_progress !== want.progress) begin
        fails++;
        if (fails <= 10) begin
          $display("ERROR: result %0d expected sel=%0d part=%0d rate=%0d prog=%0d", checked,
                   want.sel, want.sel_idx, want.rate, want.progress);
          $display("       got      sel=%0d part=%0d rate=%0d prog=%0d",
                   selection_valid, selected_partition, transmit_rate, packet_progress);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pkt_bits  = '0;
      rate_cfg  = '0;
      cur_part  = '0;
      cur_valid = 1'b0;
      sent_bits = '0;
      clear_tick();
      expected_selections.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PACKET_BITS: pkt_bits = cfg_data;
          REG_RATE:        rate_cfg = cfg_data[RATE_W-1:0];
          default:         ;
        endcase
      end
      if (in_valid && !in_stall) begin
        schedule_partition(partition_index, stored_bits, last_partition, ground_access,
                           elapsed_ticks);
      end
      if (out_valid && !out_stall) begin
        check_result();
      end
    end
    pending_results <= expected_selections.size();
    fail_count      <= fails;
    checked_results <= checked;
  end

endmodule

// File: test/downlink_partition_scheduler_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// downlink_partition_scheduler_tb
// Drives partition fill levels into the scheduler, tick by tick. A short
// directed sequence comes first. Random ticks follow under a range of
// register settings and back-pressure patterns. A checker beside the block
// predicts and compares every result beat.
// ----------------------------------------------------------------------------
module downlink_partition_scheduler_tb;
  import dps_pkg::*;

  localparam int RANDOM_BEATS = 900;
  localparam int PHASES       = 8;
  localparam int QUIET_LIMIT  = 5000;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [IDX_W-1:0]   partition_index;
  logic [BITS_W-1:0]  stored_bits;
  logic               last_partition;
  logic               ground_access;
  logic [TICKS_W-1:0] elapsed_ticks;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               selection_valid;
  logic [IDX_W-1:0]   selected_partition;
  logic [RATE_W-1:0]  transmit_rate;
  logic [BITS_W-1:0]  packet_progress;
  logic               cfg_valid;
  logic               cfg_ready;
  cfg_reg_t           cfg_index;
  logic [BITS_W-1:0]  cfg_data;

  int fail_count;
  int pending_results;
  int checked_results;

  int gap_pct   = 0;
  int stall_pct = 0;
  int beats_sent = 0;
  int ticks_sent = 0;
  int settings_used = 0;

  logic [BITS_W-1:0] pkt_now = '0;
  logic [BITS_W-1:0] fill [DPS_PARTITIONS];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  downlink_partition_scheduler u_top (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .partition_index    (partition_index),
    .stored_bits        (stored_bits),
    .last_partition     (last_partition),
    .ground_access      (ground_access),
    .elapsed_ticks      (elapsed_ticks),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .selection_valid    (selection_valid),
    .selected_partition (selected_partition),
    .transmit_rate      (transmit_rate),
    .packet_progress    (packet_progress),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  downlink_partition_scheduler_checker u_checker (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .partition_index    (partition_index),
    .stored_bits        (stored_bits),
    .last_partition     (last_partition),
    .ground_access      (ground_access),
    .elapsed_ticks      (elapsed_ticks),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .selection_valid    (selection_valid),
    .selected_partition (selected_partition),
    .transmit_rate      (transmit_rate),
    .packet_progress    (packet_progress),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .fail_count         (fail_count),
    .pending_results    (pending_results),
    .checked_results    (checked_results)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // valid stays up between back-to-back beats; it only drops on a gap
  task automatic send_beat(input logic [IDX_W-1:0]   idx,
                           input logic [BITS_W-1:0]  amount,
                           input logic               closing,
                           input logic               access,
                           input logic [TICKS_W-1:0] ticks);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    partition_index <= idx;
    stored_bits     <= amount;
    last_partition  <= closing;
    ground_access   <= access;
    elapsed_ticks   <= ticks;
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  // a trailing non-closing beat may still sit in the input register
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config(input logic [BITS_W-1:0] pkt, input logic [RATE_W-1:0] rate);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= REG_PACKET_BITS;
    cfg_data  <= pkt;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_RATE;
    cfg_data  <= {{(BITS_W-RATE_W){1'b0}}, rate};
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pkt_now = pkt;
    settings_used++;
  endtask

  // fill levels drift: often kept, sometimes emptied, full, close to a packet or random
  function automatic logic [BITS_W-1:0] next_fill(input logic [BITS_W-1:0] old);
    int roll;
    roll = $urandom_range(99);
    if (roll < 50) return old;
    if (roll < 60) return '0;
    if (roll < 65) return '1;
    if (roll < 85) return pkt_now + BITS_W'($urandom_range(4)) - BITS_W'(2);
    return $urandom();
  endfunction

  function automatic logic [TICKS_W-1:0] pick_ticks();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return '0;
    if (roll < 20) return '1;
    if (roll < 30) return TICKS_W'($urandom_range(16'hFFFF));
    return TICKS_W'($urandom_range(1, 16));
  endfunction

  task automatic random_tick();
    int shape;
    logic [IDX_W-1:0] idx;
    for (int p = 0; p < DPS_PARTITIONS; p++) fill[p] = next_fill(fill[p]);
    shape = $urandom_range(99);
    if (shape < 8) begin
      // noise: any beat at all, closing or not
      send_beat(IDX_W'($urandom_range(15)), $urandom(), 1'($urandom_range(1)),
                1'($urandom_range(1)), TICKS_W'($urandom_range(16'hFFFF)));
    end else begin
      if (shape < 50) begin
        for (int p = 0; p < DPS_PARTITIONS - 1; p++) begin
          send_beat(IDX_W'(p), fill[p], 1'b0, 1'($urandom_range(1)),
                    TICKS_W'($urandom_range(16'hFFFF)));
        end
        idx = IDX_W'(DPS_PARTITIONS - 1);
      end else if (shape < 75) begin
        for (int p = 0; p < DPS_PARTITIONS - 1; p++) begin
          if ($urandom_range(3) != 0) begin
            send_beat(IDX_W'(p), fill[p], 1'b0, 1'($urandom_range(1)),
                      TICKS_W'($urandom_range(16'hFFFF)));
          end
        end
        idx = IDX_W'($urandom_range(15));
      end else begin
        repeat ($urandom_range(7)) begin
          idx = IDX_W'($urandom_range(15));
          send_beat(idx, fill[idx], 1'b0, 1'($urandom_range(1)),
                    TICKS_W'($urandom_range(16'hFFFF)));
        end
        idx = IDX_W'($urandom_range(15));
      end
      send_beat(idx, fill[idx], 1'b1, $urandom_range(99) < 85, pick_ticks());
      ticks_sent++;
    end
  endtask

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Timeout: no beat moved for %0d cycles", QUIET_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    int stop;
    rst             = 1'b1;
    in_valid        = 1'b0;
    partition_index = '0;
    stored_bits     = '0;
    last_partition  = 1'b0;
    ground_access   = 1'b0;
    elapsed_ticks   = '0;
    cfg_valid       = 1'b0;
    cfg_index       = REG_PACKET_BITS;
    cfg_data        = '0;
    for (int p = 0; p < DPS_PARTITIONS; p++) fill[p] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset settings: zero packet size, zero rate
    send_beat(4'd0, 32'd0, 1'b1, 1'b1, 16'd0);
    ticks_sent++;

    write_config(32'd1000, 24'd300);
    // tie on amount: lower index listed first wins
    send_beat(4'd3, 32'd5000, 1'b0, 1'b0, 16'd0);
    send_beat(4'd7, 32'd5000, 1'b0, 1'b0, 16'd0);
    send_beat(4'd0, 32'd0, 1'b1, 1'b1, 16'd2);
    send_beat(4'd3, 32'd5000, 1'b1, 1'b1, 16'd1);
    // current partition seen empty mid-packet
    send_beat(4'd3, 32'd0, 1'b0, 1'b0, 16'd0);
    send_beat(4'd5, 32'd2000, 1'b1, 1'b1, 16'd1);
    // current partition missing from the tick
    send_beat(4'd9, 32'd4000, 1'b1, 1'b1, 16'd3);
    // no ground station in view
    send_beat(4'd9, 32'd4000, 1'b1, 1'b0, 16'd1);
    // short of one packet
    send_beat(4'd2, 32'd10, 1'b1, 1'b1, 16'd5);
    // rate * ticks beyond what is stored
    send_beat(4'd4, 32'd1500, 1'b1, 1'b1, 16'd10);
    // packet done, duplicate indexes in one tick
    send_beat(4'd4, 32'd2000, 1'b0, 1'b0, 16'd0);
    send_beat(4'd4, 32'd0, 1'b0, 1'b0, 16'd0);
    send_beat(4'd1, 32'd1500, 1'b1, 1'b1, 16'd1);
    send_beat(4'd4, 32'd0, 1'b0, 1'b0, 16'd0);
    send_beat(4'd4, 32'd2500, 1'b1, 1'b1, 16'd1);
    send_beat(4'd15, 32'hFFFF_FFFF, 1'b1, 1'b1, 16'hFFFF);
    ticks_sent += 10;

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: write_config(32'd1000, 24'd300);
        1: write_config(32'hFFFF_FFFF, 24'hFF_FFFF);
        2: write_config(32'd0, 24'hFF_FFFF);
        3: write_config(32'd1, 24'd0);
        4: write_config(32'd50000, 24'd7);
        5: write_config(32'd4000, 24'd900);
        default: write_config(BITS_W'($urandom_range(1, 1 << 20)),
                              RATE_W'($urandom_range(1, 1 << 16)));
      endcase
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 50; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 50; end
        default: begin gap_pct = 30; stall_pct = 30; end
      endcase
      stop = beats_sent + RANDOM_BEATS / PHASES;
      while (beats_sent < stop) random_tick();
      // close any tick left open by a noise beat
      send_beat(IDX_W'($urandom_range(15)), $urandom(), 1'b1, 1'b1, pick_ticks());
      ticks_sent++;
    end

    gap_pct   = 0;
    stall_pct = 0;
    wait_idle();
    $display("Run covered %0d partition beats in %0d ticks under %0d register settings",
             beats_sent, ticks_sent, settings_used);
    $display("%0d results compared, with sender gaps and receiver stalls in turn",
             checked_results);
    if (fail_count == 0 && pending_results == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
